@@ hw/rtl/tgc_pkg.sv @@
package tgc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TS_BITS        = 32;
  localparam int PRESS_BITS     = 16;
  localparam int CFG_DW         = 16;
  localparam int CFG_IW         = 3;
  localparam int SWIPE_BITS     = 3;

  localparam logic [CFG_IW-1:0] REG_ROTATION  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WIDTH     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_HEIGHT    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_PRESS_MS  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 3'd4;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [SWIPE_BITS-1:0] SWIPE_NO_DIR = 3'd0;
  localparam logic [SWIPE_BITS-1:0] SWIPE_RIGHT  = 3'd1;
  localparam logic [SWIPE_BITS-1:0] SWIPE_LEFT   = 3'd2;
  localparam logic [SWIPE_BITS-1:0] SWIPE_DOWN   = 3'd3;
  localparam logic [SWIPE_BITS-1:0] SWIPE_UP     = 3'd4;

  localparam int RST_WIDTH     = 240;
  localparam int RST_HEIGHT    = 320;
  localparam int RST_PRESS_MS  = 500;
  localparam int RST_THRESHOLD = 30;

endpackage

@@ hw/rtl/tgc_if.sv @@
interface tgc_in_if #(
  parameter int CW = tgc_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         touching;
  logic                         pos_valid;
  logic [CW-1:0]                raw_x;
  logic [CW-1:0]                raw_y;
  logic [tgc_pkg::TS_BITS-1:0]  now_ms;

  modport source (output valid, cmd, touching, pos_valid, raw_x, raw_y, now_ms,
                  input ready);
  modport sink   (input valid, cmd, touching, pos_valid, raw_x, raw_y, now_ms,
                  output ready);
endinterface

interface tgc_out_if #(
  parameter int CW = tgc_pkg::COORD_BITS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic [CW-1:0]                   touch_x;
  logic [CW-1:0]                   touch_y;
  logic                            held;
  logic                            pressed;
  logic                            released;
  logic [tgc_pkg::SWIPE_BITS-1:0]  swipe;

  modport source (output valid, touch_x, touch_y, held, pressed, released, swipe,
                  input ready);
  modport sink   (input valid, touch_x, touch_y, held, pressed, released, swipe,
                  output ready);
endinterface

@@ hw/rtl/tgc_rotate.sv @@
module tgc_rotate #(
  parameter int CW = tgc_pkg::COORD_BITS_DEF
) (
  input  logic [1:0]    rotation,
  input  logic [CW-1:0] panel_width,
  input  logic [CW-1:0] panel_height,
  input  logic [CW-1:0] raw_x,
  input  logic [CW-1:0] raw_y,
  output logic [CW-1:0] rot_x,
  output logic [CW-1:0] rot_y
);

  logic [CW-1:0] w_minus_x;
  logic [CW-1:0] h_minus_y;

  // A negative result saturates to zero.
  assign w_minus_x = (panel_width > raw_x)  ? (panel_width - raw_x)  : '0;
  assign h_minus_y = (panel_height > raw_y) ? (panel_height - raw_y) : '0;

  always_comb begin
    case (rotation)
      tgc_pkg::ROT_0: begin
        rot_x = raw_x;
        rot_y = raw_y;
      end
      tgc_pkg::ROT_90: begin
        rot_x = h_minus_y;
        rot_y = raw_x;
      end
      tgc_pkg::ROT_180: begin
        rot_x = w_minus_x;
        rot_y = h_minus_y;
      end
      tgc_pkg::ROT_270: begin
        rot_x = raw_y;
        rot_y = w_minus_x;
      end
      default: begin
        rot_x = raw_x;
        rot_y = raw_y;
      end
    endcase
  end

endmodule

@@ hw/rtl/touch_gesture_classifier_core.sv @@
// Touch gesture classifier: turns a stream of panel poll beats into touch start
// coordinates, held / long-press / release flags and a swipe direction.
// The in_if channel carries one poll or clear command per beat; every beat
// yields exactly one beat on out_if holding the updated gesture state.
// The cfg_ port writes rotation, panel size, press time and swipe threshold;
// write it only while no beat is in flight.
// From an accepted input beat to its output beat, the rotated coordinate is
// registered on entry, and the gesture state update is registered into the
// output, whose payload is the gesture state itself.
// Throughput is one beat per cycle while out_if.ready stays high.
// When the receiver stalls, the output beat holds, the input register fills,
// and in_if.ready drops until the output is taken.
// A synchronous active-low reset empties both stages, clears the gesture
// state and loads the default configuration.
module touch_gesture_classifier_core #(
  parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tgc_in_if.sink                        in_if,
  tgc_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [tgc_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [tgc_pkg::CFG_DW-1:0]    cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int TW = tgc_pkg::TS_BITS;

  logic [1:0]                     rotation_r;
  logic [CW-1:0]                  panel_width_r;
  logic [CW-1:0]                  panel_height_r;
  logic [tgc_pkg::PRESS_BITS-1:0] press_ms_r;
  logic [CW-1:0]                  threshold_r;

  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_cmd_r, s1_touching_r, s1_pos_valid_r;
  logic [CW-1:0] s1_x_r, s1_y_r;
  logic [TW-1:0] s1_now_r;
  logic [CW-1:0] rot_x, rot_y;

  logic          out_valid_r, out_valid_nxt;
  logic          in_take, advance;

  logic [CW-1:0]                  start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [CW-1:0]                  end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic [TW-1:0]                  hold_start_r, hold_start_nxt;
  logic                           active_r, active_nxt;
  logic                           press_r, press_nxt;
  logic                           release_r, release_nxt;
  logic                           skip_r, skip_nxt;
  logic                           held_r, held_nxt;
  logic [tgc_pkg::SWIPE_BITS-1:0] swipe_r, swipe_nxt;

  logic [CW-1:0] dx, dy;
  logic [TW-1:0] elapsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r     <= tgc_pkg::ROT_0;
      panel_width_r  <= CW'(tgc_pkg::RST_WIDTH);
      panel_height_r <= CW'(tgc_pkg::RST_HEIGHT);
      press_ms_r     <= tgc_pkg::PRESS_BITS'(tgc_pkg::RST_PRESS_MS);
      threshold_r    <= CW'(tgc_pkg::RST_THRESHOLD);
    end else if (cfg_we) begin
      case (cfg_index)
        tgc_pkg::REG_ROTATION:  rotation_r     <= cfg_data[1:0];
        tgc_pkg::REG_WIDTH:     panel_width_r  <= cfg_data[CW-1:0];
        tgc_pkg::REG_HEIGHT:    panel_height_r <= cfg_data[CW-1:0];
        tgc_pkg::REG_PRESS_MS:  press_ms_r     <= cfg_data[tgc_pkg::PRESS_BITS-1:0];
        tgc_pkg::REG_THRESHOLD: threshold_r    <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  tgc_rotate #(.CW(CW)) u_rotate (
    .rotation     (rotation_r),
    .panel_width  (panel_width_r),
    .panel_height (panel_height_r),
    .raw_x        (in_if.raw_x),
    .raw_y        (in_if.raw_y),
    .rot_x        (rot_x),
    .rot_y        (rot_y)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r       <= in_if.cmd;
      s1_touching_r  <= in_if.touching;
      s1_pos_valid_r <= in_if.pos_valid;
      s1_x_r         <= rot_x;
      s1_y_r         <= rot_y;
      s1_now_r       <= in_if.now_ms;
    end
  end

  assign elapsed = s1_now_r - hold_start_r;

  always_comb begin
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    end_x_nxt      = end_x_r;
    end_y_nxt      = end_y_r;
    hold_start_nxt = hold_start_r;
    active_nxt     = active_r;
    press_nxt      = press_r;
    release_nxt    = release_r;
    skip_nxt       = skip_r;
    held_nxt       = held_r;
    swipe_nxt      = swipe_r;
    dx             = '0;
    dy             = '0;
    if (s1_cmd_r) begin
      held_nxt    = 1'b0;
      press_nxt   = 1'b0;
      release_nxt = 1'b0;
      active_nxt  = 1'b0;
      swipe_nxt   = tgc_pkg::SWIPE_NO_DIR;
      start_x_nxt = '0;
      start_y_nxt = '0;
      end_x_nxt   = '0;
      end_y_nxt   = '0;
    end else begin
      held_nxt = s1_touching_r;
      if (s1_pos_valid_r) begin
        end_x_nxt = s1_x_r;
        end_y_nxt = s1_y_r;
        if (!s1_touching_r) begin
          start_x_nxt = s1_x_r;
          start_y_nxt = s1_y_r;
        end
      end
      dx = (start_x_nxt > end_x_nxt) ? (start_x_nxt - end_x_nxt)
                                     : (end_x_nxt - start_x_nxt);
      dy = (start_y_nxt > end_y_nxt) ? (start_y_nxt - end_y_nxt)
                                     : (end_y_nxt - start_y_nxt);
      if (skip_r) begin
        // The poll after a long press only refreshes contact and position.
        skip_nxt = 1'b0;
      end else if (!s1_touching_r) begin
        if (active_r) begin
          active_nxt  = 1'b0;
          release_nxt = 1'b1;
          if (dx > threshold_r || dy > threshold_r) begin
            if (dx >= dy) begin
              swipe_nxt = (start_x_nxt > end_x_nxt) ? tgc_pkg::SWIPE_RIGHT
                                                    : tgc_pkg::SWIPE_LEFT;
            end else begin
              swipe_nxt = (start_y_nxt > end_y_nxt) ? tgc_pkg::SWIPE_DOWN
                                                    : tgc_pkg::SWIPE_UP;
            end
          end
        end
      end else if (active_r) begin
        if (!press_r && (elapsed > TW'(press_ms_r))) begin
          active_nxt = 1'b0;
          press_nxt  = 1'b1;
          skip_nxt   = 1'b1;
        end
      end else begin
        active_nxt     = 1'b1;
        release_nxt    = 1'b0;
        hold_start_nxt = s1_now_r;
        start_x_nxt    = end_x_nxt;
        start_y_nxt    = end_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      hold_start_r <= '0;
      active_r     <= 1'b0;
      press_r      <= 1'b0;
      release_r    <= 1'b0;
      skip_r       <= 1'b0;
      held_r       <= 1'b0;
      swipe_r      <= tgc_pkg::SWIPE_NO_DIR;
    end else if (advance) begin
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      end_x_r      <= end_x_nxt;
      end_y_r      <= end_y_nxt;
      hold_start_r <= hold_start_nxt;
      active_r     <= active_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
      skip_r       <= skip_nxt;
      held_r       <= held_nxt;
      swipe_r      <= swipe_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.touch_x  = start_x_r;
  assign out_if.touch_y  = start_y_r;
  assign out_if.held     = held_r;
  assign out_if.pressed  = press_r;
  assign out_if.released = release_r;
  assign out_if.swipe    = swipe_r;

endmodule

@@ sim/touch_gesture_classifier_core_tb.sv @@
module touch_gesture_classifier_core_tb;

  localparam int CW          = tgc_pkg::COORD_BITS_DEF;
  localparam int TSW         = tgc_pkg::TS_BITS;
  localparam int PW          = tgc_pkg::PRESS_BITS;
  localparam int SW          = tgc_pkg::SWIPE_BITS;
  localparam int IW          = tgc_pkg::CFG_IW;
  localparam int DW          = tgc_pkg::CFG_DW;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 250;
  localparam int N_PHASES    = 10;
  localparam int PHASE_BEATS = 130;

  typedef struct packed {
    logic            cmd;
    logic            touching;
    logic            pos_valid;
    logic [CW-1:0]   raw_x;
    logic [CW-1:0]   raw_y;
    logic [TSW-1:0]  now_ms;
  } poll_t;

  localparam int POLL_BITS = $bits(poll_t);

  typedef struct packed {
    logic [CW-1:0] touch_x;
    logic [CW-1:0] touch_y;
    logic          held;
    logic          pressed;
    logic          released;
    logic [SW-1:0] swipe;
  } gesture_t;

  class gesture_scoreboard;
    logic [1:0]     rot;
    logic [CW-1:0]  width;
    logic [CW-1:0]  height;
    logic [PW-1:0]  press;
    logic [CW-1:0]  thr;
    logic [CW-1:0]  sx, sy, ex, ey;
    logic [TSW-1:0] hold_t;
    bit             active, pressed, released, skip, held;
    logic [SW-1:0]  swipe;
    gesture_t       expected_q[$];
    int             errors, n_checked, n_swipes, n_presses, n_clears;

    function new();
      rot = tgc_pkg::ROT_0;
      width = CW'(tgc_pkg::RST_WIDTH);
      height = CW'(tgc_pkg::RST_HEIGHT);
      press = PW'(tgc_pkg::RST_PRESS_MS);
      thr = CW'(tgc_pkg::RST_THRESHOLD);
      sx = '0; sy = '0; ex = '0; ey = '0;
      hold_t = '0;
      active = 0; pressed = 0; released = 0; skip = 0; held = 0;
      swipe = tgc_pkg::SWIPE_NO_DIR;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] d);
      case (idx)
        tgc_pkg::REG_ROTATION:  rot = d[1:0];
        tgc_pkg::REG_WIDTH:     width = d[CW-1:0];
        tgc_pkg::REG_HEIGHT:    height = d[CW-1:0];
        tgc_pkg::REG_PRESS_MS:  press = d[PW-1:0];
        tgc_pkg::REG_THRESHOLD: thr = d[CW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CW-1:0] sat_sub(logic [CW-1:0] a, logic [CW-1:0] b);
      return (a > b) ? a - b : '0;
    endfunction

    function void note_beat(poll_t p);
      logic [CW-1:0] rx, ry, dx, dy;
      gesture_t r;
      if (p.cmd) begin
        held = 0; pressed = 0; released = 0; active = 0;
        swipe = tgc_pkg::SWIPE_NO_DIR;
        sx = '0; sy = '0; ex = '0; ey = '0;
        n_clears++;
      end else begin
        held = p.touching;
        if (p.pos_valid) begin
          case (rot)
            tgc_pkg::ROT_90: begin
              rx = sat_sub(height, p.raw_y);
              ry = p.raw_x;
            end
            tgc_pkg::ROT_180: begin
              rx = sat_sub(width, p.raw_x);
              ry = sat_sub(height, p.raw_y);
            end
            tgc_pkg::ROT_270: begin
              rx = p.raw_y;
              ry = sat_sub(width, p.raw_x);
            end
            default: begin
              rx = p.raw_x;
              ry = p.raw_y;
            end
          endcase
          ex = rx;
          ey = ry;
          if (!held) begin
            sx = rx;
            sy = ry;
          end
        end
        if (skip) begin
          skip = 0;
        end else if (!held) begin
          if (active) begin
            dx = (sx > ex) ? sx - ex : ex - sx;
            dy = (sy > ey) ? sy - ey : ey - sy;
            active = 0;
            released = 1;
            if (dx > thr || dy > thr) begin
              if (dx >= dy) swipe = (sx > ex) ? tgc_pkg::SWIPE_RIGHT : tgc_pkg::SWIPE_LEFT;
              else swipe = (sy > ey) ? tgc_pkg::SWIPE_DOWN : tgc_pkg::SWIPE_UP;
              n_swipes++;
            end
          end
        end else if (active) begin
          if (!pressed && (p.now_ms - hold_t) > {16'd0, press}) begin
            active = 0;
            pressed = 1;
            skip = 1;
            n_presses++;
          end
        end else begin
          active = 1;
          released = 0;
          hold_t = p.now_ms;
          sx = ex;
          sy = ey;
        end
      end
      r.touch_x = sx;
      r.touch_y = sy;
      r.held = held;
      r.pressed = pressed;
      r.released = released;
      r.swipe = swipe;
      expected_q.push_back(r);
    endfunction

    function void check_beat(gesture_t got);
      gesture_t want;
      if (expected_q.size() == 0) begin
        $error("output beat with no poll waiting: x=%0d y=%0d swipe=%0d",
               got.touch_x, got.touch_y, got.swipe);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.touch_x !== want.touch_x) begin
        $error("touch_x: expected %0d, actual %0d", want.touch_x, got.touch_x);
        errors++;
      end
      if (got.touch_y !== want.touch_y) begin
        $error("touch_y: expected %0d, actual %0d", want.touch_y, got.touch_y);
        errors++;
      end
      if (got.held !== want.held) begin
        $error("held: expected %0d, actual %0d", want.held, got.held);
        errors++;
      end
      if (got.pressed !== want.pressed) begin
        $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
        errors++;
      end
      if (got.released !== want.released) begin
        $error("released: expected %0d, actual %0d", want.released, got.released);
        errors++;
      end
      if (got.swipe !== want.swipe) begin
        $error("swipe: expected %0d, actual %0d", want.swipe, got.swipe);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  tgc_in_if  #(.CW(CW)) in_bus ();
  tgc_out_if #(.CW(CW)) out_bus ();

  touch_gesture_classifier_core #(.COORD_BITS(CW)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gesture_scoreboard sb;
  bit                idle_on;
  bit                hold_req;
  int                n_sent;
  int                n_settings;
  logic [TSW-1:0]    now_t;
  logic [PW-1:0]     cur_press;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("touch_gesture_classifier_core_tb: FAIL");
    $finish;
  end

  // Input beats are noted before output beats are checked in the same cycle.
  always @(posedge clk) begin
    poll_t    pb;
    gesture_t gb;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        pb.cmd = in_bus.cmd;
        pb.touching = in_bus.touching;
        pb.pos_valid = in_bus.pos_valid;
        pb.raw_x = in_bus.raw_x;
        pb.raw_y = in_bus.raw_y;
        pb.now_ms = in_bus.now_ms;
        sb.note_beat(pb);
      end
      if (out_bus.valid && out_bus.ready) begin
        gb.touch_x = out_bus.touch_x;
        gb.touch_y = out_bus.touch_y;
        gb.held = out_bus.held;
        gb.pressed = out_bus.pressed;
        gb.released = out_bus.released;
        gb.swipe = out_bus.swipe;
        sb.check_beat(gb);
      end
    end
  end

  initial begin
    int hold_cnt;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic logic [CW-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'd4095;
    return v[CW-1:0];
  endfunction

  task automatic send_beat(poll_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= p.cmd;
    in_bus.touching <= p.touching;
    in_bus.pos_valid <= p.pos_valid;
    in_bus.raw_x <= p.raw_x;
    in_bus.raw_y <= p.raw_y;
    in_bus.now_ms <= p.now_ms;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic poll(bit touching, bit pos_valid, logic [CW-1:0] x, logic [CW-1:0] y);
    poll_t p;
    p.cmd = 1'b0;
    p.touching = touching;
    p.pos_valid = pos_valid;
    p.raw_x = x;
    p.raw_y = y;
    p.now_ms = now_t;
    send_beat(p);
  endtask

  task automatic send_random(bit is_clear);
    poll_t p;
    p = POLL_BITS'({$urandom, $urandom});
    p.cmd = is_clear;
    send_beat(p);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [1:0] rot, logic [CW-1:0] w, logic [CW-1:0] h,
                              logic [PW-1:0] press, logic [CW-1:0] thr);
    logic [DW-1:0] vals[5];
    logic [IW-1:0] idxs[5];
    int i;
    idxs = '{tgc_pkg::REG_ROTATION, tgc_pkg::REG_WIDTH, tgc_pkg::REG_HEIGHT,
             tgc_pkg::REG_PRESS_MS, tgc_pkg::REG_THRESHOLD};
    vals = '{DW'(rot), DW'(w), DW'(h), DW'(press), DW'(thr)};
    for (i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    cur_press = press;
    n_settings++;
  endtask

  task automatic run_gesture();
    int x, y, vx, vy, jx, jy, n, k;
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    vx = $urandom_range(0, 600);
    vy = $urandom_range(0, 600);
    vx = vx - 300;
    vy = vy - 300;
    if ($urandom_range(0, 19) == 0) now_t = 32'hFFFF_FFFF - $urandom_range(0, 400);
    now_t += $urandom_range(1, 40);
    poll(1'b1, $urandom_range(0, 9) != 0, clamp_coord(x), clamp_coord(y));
    n = $urandom_range(0, 8);
    for (k = 0; k < n; k++) begin
      jx = $urandom_range(0, 20);
      jy = $urandom_range(0, 20);
      x = int'(clamp_coord(x + vx + jx - 10));
      y = int'(clamp_coord(y + vy + jy - 10));
      now_t += $urandom_range(1, 40);
      poll($urandom_range(0, 19) != 0, $urandom_range(0, 4) != 0,
           clamp_coord(x), clamp_coord(y));
    end
    if ($urandom_range(0, 3) == 0) begin
      now_t += {16'd0, cur_press} + $urandom_range(1, 60);
      poll(1'b1, 1'($urandom_range(0, 1)), clamp_coord(x), clamp_coord(y));
      now_t += $urandom_range(1, 40);
      poll(1'b1, 1'($urandom_range(0, 1)), clamp_coord(x), clamp_coord(y));
    end
    now_t += $urandom_range(1, 40);
    poll(1'b0, $urandom_range(0, 2) != 0, clamp_coord(x), clamp_coord(y));
  endtask

  initial begin
    int ph, start_cnt, pick, n_directed;
    logic [1:0]    r_rot;
    logic [CW-1:0] r_w, r_h, r_thr;
    logic [PW-1:0] r_press;
    sb = new();
    idle_on = 1;
    hold_req = 0;
    n_sent = 0;
    n_settings = 1;
    now_t = 32'd1000;
    cur_press = PW'(tgc_pkg::RST_PRESS_MS);
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.cmd <= 1'b0;
    in_bus.touching <= 1'b0;
    in_bus.pos_valid <= 1'b0;
    in_bus.raw_x <= '0;
    in_bus.raw_y <= '0;
    in_bus.now_ms <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    poll(1'b0, 1'b1, 12'd0, 12'd0);
    now_t = 32'd1000; poll(1'b1, 1'b1, 12'd4095, 12'd4095);
    now_t = 32'd1010; poll(1'b1, 1'b1, 12'd0, 12'd0);
    now_t = 32'd1020; poll(1'b0, 1'b1, 12'd0, 12'd0);
    now_t = 32'd2000; poll(1'b1, 1'b1, 12'd100, 12'd100);
    now_t = 32'd2010; poll(1'b1, 1'b1, 12'd100, 12'd200);
    now_t = 32'd2020; poll(1'b0, 1'b0, 12'd0, 12'd0);
    now_t = 32'd2100; poll(1'b1, 1'b1, 12'd100, 12'd300);
    now_t = 32'd2110; poll(1'b1, 1'b1, 12'd100, 12'd100);
    now_t = 32'd2120; poll(1'b0, 1'b1, 12'd100, 12'd100);
    // Equal travel on both axes, lifted with a valid position, keeps the swipe code.
    now_t = 32'd3000; poll(1'b1, 1'b1, 12'd100, 12'd100);
    now_t = 32'd3010; poll(1'b1, 1'b1, 12'd150, 12'd150);
    now_t = 32'd3020; poll(1'b0, 1'b1, 12'd150, 12'd150);
    // Short travel keeps the previous swipe code.
    now_t = 32'd4000; poll(1'b1, 1'b1, 12'd10, 12'd10);
    now_t = 32'd4010; poll(1'b0, 1'b1, 12'd12, 12'd12);
    now_t = 32'd5000; poll(1'b1, 1'b1, 12'd10, 12'd10);
    now_t = 32'd5600; poll(1'b1, 1'b0, 12'd0, 12'd0);
    now_t = 32'd5610; poll(1'b1, 1'b1, 12'd20, 12'd20);
    now_t = 32'd5620; poll(1'b1, 1'b1, 12'd30, 12'd30);
    now_t = 32'd5630; poll(1'b0, 1'b1, 12'd30, 12'd30);
    // Long press across the timestamp wrap, then a lift that gives no release.
    send_random(1'b1);
    now_t = 32'hFFFF_FF00; poll(1'b1, 1'b1, 12'd2000, 12'd2000);
    now_t = 32'h0000_0100; poll(1'b1, 1'b1, 12'd2000, 12'd2000);
    now_t = 32'h0000_0110; poll(1'b0, 1'b1, 12'd2000, 12'd2000);
    now_t = 32'h0000_0120; poll(1'b0, 1'b1, 12'd2000, 12'd2000);

    wait_idle();
    apply_config(tgc_pkg::ROT_90, 12'd100, 12'd50, 16'd500, 12'd30);
    poll(1'b0, 1'b1, 12'd4095, 12'd4095);
    wait_idle();
    apply_config(tgc_pkg::ROT_180, 12'd100, 12'd50, 16'd500, 12'd30);
    poll(1'b0, 1'b1, 12'd4095, 12'd20);
    wait_idle();
    apply_config(tgc_pkg::ROT_270, 12'd100, 12'd50, 16'd500, 12'd30);
    poll(1'b0, 1'b1, 12'd4095, 12'd4095);
    n_directed = n_sent;

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: apply_config(tgc_pkg::ROT_0, CW'(tgc_pkg::RST_WIDTH), CW'(tgc_pkg::RST_HEIGHT),
                        PW'(tgc_pkg::RST_PRESS_MS), CW'(tgc_pkg::RST_THRESHOLD));
        1: apply_config(tgc_pkg::ROT_90, 12'd4095, 12'd4095, 16'd0, 12'd0);
        2: apply_config(tgc_pkg::ROT_180, 12'd0, 12'd0, 16'hFFFF, 12'd4095);
        default: begin
          r_rot = 2'($urandom_range(0, 3));
          r_w = ($urandom_range(0, 4) == 0) ? 12'd4095 : 12'($urandom_range(0, 4095));
          r_h = ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
          r_press = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(10, 400));
          r_thr = ($urandom_range(0, 5) == 0) ? 12'd0 : 12'($urandom_range(0, 300));
          apply_config(r_rot, r_w, r_h, r_press, r_thr);
        end
      endcase
      idle_on = (ph != N_PHASES - 1);
      if (ph == 1 || ph == 5) hold_req = 1;
      start_cnt = n_sent;
      while (n_sent - start_cnt < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) run_gesture();
        else if (pick < 92) send_random(1'b0);
        else send_random(1'b1);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input beats (%0d directed) over %0d register settings,",
             n_sent, n_directed, n_settings);
    $display("%0d checked; predicted %0d swipes, %0d long presses and %0d clear commands.",
             sb.n_checked, sb.n_swipes, sb.n_presses, sb.n_clears);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("touch_gesture_classifier_core_tb: PASS");
    end else begin
      $display("touch_gesture_classifier_core_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ touch_gesture_classifier_core.f @@
hw/rtl/tgc_pkg.sv
hw/rtl/tgc_if.sv
hw/rtl/tgc_rotate.sv
hw/rtl/touch_gesture_classifier_core.sv
sim/touch_gesture_classifier_core_tb.sv
